@@ sv/tbtd_pkg.sv @@
// Shared types, constants and pair table for the tape block text deframer.
package tbtd_pkg;

    // Parser phases of the front end.
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TRAILER,
        PH_PAYLOAD,
        PH_ESC1,
        PH_ESC2,
        PH_DONE
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_HEADER_SKIP  = 1'b0,
        REG_TRAILER_SKIP = 1'b1
    } t_reg_idx;

    localparam logic [7:0] C_HEADER_SKIP_RST  = 8'h36;
    localparam logic [7:0] C_TRAILER_SKIP_RST = 8'd20;
    localparam logic [7:0] C_FULL_LEN         = 8'd254;
    localparam logic [7:0] C_ESC_BYTE         = 8'h16;
    localparam logic [7:0] C_CR_BYTE          = 8'h0D;
    localparam logic [7:0] C_LF_BYTE          = 8'h0A;

    // Character queue between parser and output stage.
    localparam int C_FIFO_DEPTH = 4;
    localparam int C_FIFO_AW    = $clog2(C_FIFO_DEPTH);
    localparam int C_FIFO_CW    = $clog2(C_FIFO_DEPTH + 1);

    localparam int C_NUM_PAIRS = 14;

    typedef logic [7:0] t_byte;

    localparam t_byte C_PAIR_A [C_NUM_PAIRS] = '{
        8'h41, 8'h43, 8'h4B, 8'h41, 8'h42, 8'h43, 8'h48,
        8'h43, 8'h48, 8'h43, 8'h48, 8'h41, 8'h43, 8'h48
    };
    localparam t_byte C_PAIR_B [C_NUM_PAIRS] = '{
        8'h61, 8'h61, 8'h63, 8'h65, 8'h65, 8'h65, 8'h65,
        8'h69, 8'h69, 8'h6F, 8'h6F, 8'h75, 8'h75, 8'h75
    };
    localparam t_byte C_PAIR_C [C_NUM_PAIRS] = '{
        8'hE0, 8'hE2, 8'hE7, 8'hE8, 8'hE9, 8'hEA, 8'hEB,
        8'hEE, 8'hEF, 8'hF4, 8'hF6, 8'hF9, 8'hFB, 8'hFC
    };

    // One character written from the parser into the queue.
    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_char_wr;

    // Map an escape pair to its accented code; an unmatched pair gives its first byte.
    function automatic t_byte pair_decode(input t_byte first, input t_byte second);
        t_byte code;
        code = first;
        for (int k = C_NUM_PAIRS - 1; k >= 0; k--) begin
            if (C_PAIR_A[k] == first && C_PAIR_B[k] == second) begin
                code = C_PAIR_C[k];
            end
        end
        return code;
    endfunction

endpackage

@@ sv/tbtd_front.sv @@
// Front end: accept tape bytes, track framing, decode escapes into characters.
module tbtd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    input  logic              i_file_start,
    input  logic [7:0]        i_header_skip,
    input  logic [7:0]        i_trailer_skip,
    output tbtd_pkg::t_char_wr o_char
);

    tbtd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_skip_count, n_skip_count;
    logic [7:0]       r_remaining, n_remaining;
    logic             r_full_block, n_full_block;
    logic [7:0]       r_escape_first, n_escape_first;

    tbtd_pkg::t_phase c_phase;
    logic [7:0]       c_skip_count;
    logic [7:0]       c_remaining;
    logic             c_full_block;
    logic [7:0]       c_escape_first;
    logic [7:0]       w_limit;
    logic [7:0]       w_len_rem;
    tbtd_pkg::t_phase w_end_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= tbtd_pkg::PH_HEADER;
            r_skip_count   <= '0;
            r_remaining    <= '0;
            r_full_block   <= 1'b0;
            r_escape_first <= '0;
        end else begin
            r_phase        <= n_phase;
            r_skip_count   <= n_skip_count;
            r_remaining    <= n_remaining;
            r_full_block   <= n_full_block;
            r_escape_first <= n_escape_first;
        end
    end

    always_comb begin
        // restart the parser on the first byte of a new image
        c_phase        = i_file_start ? tbtd_pkg::PH_HEADER : r_phase;
        c_skip_count   = i_file_start ? 8'd0 : r_skip_count;
        c_remaining    = i_file_start ? 8'd0 : r_remaining;
        c_full_block   = i_file_start ? 1'b0 : r_full_block;
        c_escape_first = i_file_start ? 8'd0 : r_escape_first;

        w_limit     = (c_phase == tbtd_pkg::PH_HEADER) ? i_header_skip : i_trailer_skip;
        w_end_phase = c_full_block ? tbtd_pkg::PH_TRAILER : tbtd_pkg::PH_DONE;
        if (i_in_byte == 8'd0) begin
            w_len_rem = tbtd_pkg::C_FULL_LEN;
        end else if (i_in_byte >= 8'd2) begin
            w_len_rem = i_in_byte - 8'd2;
        end else begin
            w_len_rem = 8'd0;
        end

        n_phase        = r_phase;
        n_skip_count   = r_skip_count;
        n_remaining    = r_remaining;
        n_full_block   = r_full_block;
        n_escape_first = r_escape_first;
        o_char.valid   = 1'b0;
        o_char.data    = i_in_byte;

        if (i_accept) begin
            n_phase        = c_phase;
            n_skip_count   = c_skip_count;
            n_remaining    = c_remaining;
            n_full_block   = c_full_block;
            n_escape_first = c_escape_first;
            case (c_phase)
                tbtd_pkg::PH_HEADER, tbtd_pkg::PH_TRAILER: begin
                    if (c_skip_count < w_limit) begin
                        n_skip_count = c_skip_count + 8'd1;
                    end else begin
                        // length byte
                        n_full_block = (i_in_byte == 8'd0);
                        n_remaining  = w_len_rem;
                        n_phase      = (w_len_rem == 8'd0) ? tbtd_pkg::PH_DONE
                                                           : tbtd_pkg::PH_PAYLOAD;
                    end
                end
                tbtd_pkg::PH_PAYLOAD: begin
                    if (i_in_byte == tbtd_pkg::C_ESC_BYTE) begin
                        n_phase = tbtd_pkg::PH_ESC1;
                    end else begin
                        o_char.valid = 1'b1;
                        n_remaining  = c_remaining - 8'd1;
                        if (c_remaining == 8'd1) begin
                            n_phase      = w_end_phase;
                            n_skip_count = 8'd0;
                        end
                    end
                end
                tbtd_pkg::PH_ESC1: begin
                    n_escape_first = i_in_byte;
                    n_phase        = tbtd_pkg::PH_ESC2;
                end
                tbtd_pkg::PH_ESC2: begin
                    o_char.valid = 1'b1;
                    o_char.data  = tbtd_pkg::pair_decode(c_escape_first, i_in_byte);
                    n_remaining  = (c_remaining >= 8'd3) ? c_remaining - 8'd3 : 8'd0;
                    if (c_remaining <= 8'd3) begin
                        n_phase      = w_end_phase;
                        n_skip_count = 8'd0;
                    end else begin
                        n_phase = tbtd_pkg::PH_PAYLOAD;
                    end
                end
                default: begin
                    n_phase = tbtd_pkg::PH_DONE;
                end
            endcase
        end
    end

endmodule

@@ sv/tbtd_fifo.sv @@
// Short character queue between the parser and the output stage.
module tbtd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbtd_pkg::t_char_wr i_wr,
    input  logic               i_rd,
    output logic [7:0]         o_rd_data,
    output logic               o_full,
    output logic               o_empty
);

    logic [7:0]                     r_mem [tbtd_pkg::C_FIFO_DEPTH];
    logic [tbtd_pkg::C_FIFO_AW-1:0] r_wr_ptr;
    logic [tbtd_pkg::C_FIFO_AW-1:0] r_rd_ptr;
    logic [tbtd_pkg::C_FIFO_CW-1:0] r_count;
    logic                           w_wr;
    logic                           w_rd;

    assign o_full    = (r_count == tbtd_pkg::C_FIFO_CW'(tbtd_pkg::C_FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr.valid && !o_full;
    assign w_rd      = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == tbtd_pkg::C_FIFO_AW'(tbtd_pkg::C_FIFO_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == tbtd_pkg::C_FIFO_AW'(tbtd_pkg::C_FIFO_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/tbtd_back.sv @@
// Back end: output register that expands CR into CR LF and marks the last byte.
module tbtd_back (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char,
    input  logic       i_char_empty,
    output logic       o_char_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_last, n_last;
    logic       r_lf_pend, n_lf_pend;
    logic       w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_lf_pend <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_lf_pend <= n_lf_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
    end

    always_comb begin
        w_free    = !r_valid || i_pop;
        n_valid   = r_valid;
        n_byte    = r_byte;
        n_last    = r_last;
        n_lf_pend = r_lf_pend;
        o_char_rd = 1'b0;
        if (w_free) begin
            if (r_lf_pend) begin
                // the LF owed to the CR just transferred
                n_valid   = 1'b1;
                n_byte    = tbtd_pkg::C_LF_BYTE;
                n_last    = 1'b1;
                n_lf_pend = 1'b0;
            end else if (!i_char_empty) begin
                o_char_rd = 1'b1;
                n_valid   = 1'b1;
                n_byte    = i_char;
                n_last    = (i_char != tbtd_pkg::C_CR_BYTE);
                n_lf_pend = (i_char == tbtd_pkg::C_CR_BYTE);
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

endmodule

@@ sv/tape_block_text_deframer_top.sv @@
// Top level of the tape block text deframer: config registers, front, queue, back.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  input    | in        | push / full          | i_in_byte, i_file_start
//  result   | out       | empty / pop          | o_out_byte, o_last
//  config   | in        | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_data
//
// One tape byte is taken per cycle while full is low; the parser classifies it
// in the cycle it is transferred and writes at most one character into a
// four-entry queue. The output register delivers one byte per cycle while pop
// is high and empty is low; a CR yields two output bytes (CR then LF), absorbed
// by the queue. Reset is synchronous and active low: parser at header phase,
// queue and output register empty, skip registers at 54 and 20. full rises
// only when the queue is full; the output side stalls by holding pop low.
module tape_block_text_deframer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tape byte channel
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    // text byte channel
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]         r_header_skip;
    logic [7:0]         r_trailer_skip;
    logic               w_accept;
    tbtd_pkg::t_char_wr w_char_wr;
    logic [7:0]         w_char;
    logic               w_char_empty;
    logic               w_char_full;
    logic               w_char_rd;

    // Skip lengths; the user sends writes only while the block is idle, unchecked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_skip  <= tbtd_pkg::C_HEADER_SKIP_RST;
            r_trailer_skip <= tbtd_pkg::C_TRAILER_SKIP_RST;
        end else if (i_cfg_we) begin
            case (tbtd_pkg::t_reg_idx'(i_cfg_idx))
                tbtd_pkg::REG_HEADER_SKIP:  r_header_skip  <= i_cfg_data;
                tbtd_pkg::REG_TRAILER_SKIP: r_trailer_skip <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A tape byte transfers whenever the queue has room for its character.
    assign full     = w_char_full;
    assign w_accept = push && !w_char_full;

    tbtd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_in_byte      (i_in_byte),
        .i_file_start   (i_file_start),
        .i_header_skip  (r_header_skip),
        .i_trailer_skip (r_trailer_skip),
        .o_char         (w_char_wr)
    );

    tbtd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_char_wr),
        .i_rd      (w_char_rd),
        .o_rd_data (w_char),
        .o_full    (w_char_full),
        .o_empty   (w_char_empty)
    );

    tbtd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (w_char),
        .i_char_empty (w_char_empty),
        .o_char_rd    (w_char_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    // The parser writes a character only for a transferred tape byte.
    a_char_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_char_wr.valid |-> w_accept)
        else $error("character written without a tape byte transfer");

    // A transferred CR is followed by its LF, which closes the input byte.
    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_out_byte == tbtd_pkg::C_CR_BYTE && !o_last)
        |=> (!empty && o_out_byte == tbtd_pkg::C_LF_BYTE && o_last))
        else $error("CR not followed by LF");

    // Reset leaves the output side empty.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");

endmodule
